/* rtl/core/uds_bl_pkg.sv */
package uds_bl_pkg;

  // one request byte as it arrives from the link
  typedef struct packed {
    logic [7:0] req_byte;
    logic       req_last;
  } req_t;

  // one response byte with the phase after the request
  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    logic [2:0] boot_phase;
  } resp_t;

  // request bytes kept per request, longest response
  localparam int unsigned HeadDepth = 9;
  localparam int unsigned RespDepth = 7;

  // configuration register indexes
  localparam logic [1:0] REG_SEED     = 2'd0;
  localparam logic [1:0] REG_XOR_MASK = 2'd1;
  localparam logic [1:0] REG_ADD_OFS  = 2'd2;
  localparam logic [1:0] REG_MAX_ATT  = 2'd3;

  // configuration reset values
  localparam logic [31:0] SeedReset    = 32'hABCD_1234;
  localparam logic [31:0] XorMaskReset = 32'hA5A5_A5A5;
  localparam logic [31:0] AddOfsReset  = 32'h0000_1234;
  localparam logic [7:0]  MaxAttReset  = 8'd3;

  // running version low half after reset
  localparam logic [15:0] RunVerReset  = 16'h0000;

  // service ids
  localparam logic [7:0] SID_DIAG_SESSION  = 8'h10;
  localparam logic [7:0] SID_ECU_RESET     = 8'h11;
  localparam logic [7:0] SID_SECURITY      = 8'h27;
  localparam logic [7:0] SID_RUN_ROUTINE   = 8'h31;
  localparam logic [7:0] SID_DOWNLOAD      = 8'h34;
  localparam logic [7:0] SID_DATA_TRANSFER = 8'h36;
  localparam logic [7:0] SID_EXIT          = 8'h37;
  localparam logic [7:0] SID_NEGATIVE      = 8'h7F;

  // positive reply offset
  localparam logic [7:0] SidPosOfs    = 8'h40;

  // security subfunctions
  localparam logic [7:0] SUB_SEED = 8'h01;
  localparam logic [7:0] SUB_KEY  = 8'h02;

  // negative response codes
  localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
  localparam logic [7:0] NRC_COND_WRONG    = 8'h33;
  localparam logic [7:0] NRC_INVALID_KEY   = 8'h35;
  localparam logic [7:0] NRC_LOCKED_OUT    = 8'h36;
  localparam logic [7:0] NRC_OUT_OF_RANGE  = 8'h72;

  // boot phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_DL_REQ    = 3'd1;
  localparam logic [2:0] PH_DOWNLOAD  = 3'd2;
  localparam logic [2:0] PH_VERIFY    = 3'd3;
  localparam logic [2:0] PH_APPLY     = 3'd4;
  localparam logic [2:0] PH_COMPLETE  = 3'd5;
  localparam logic [2:0] PH_ROLLBACK  = 3'd6;

endpackage

/* rtl/core/uds_bootloader_service_handler.sv */
// Diagnostic bootloader service handler. Request bytes enter one per cycle on
// the input channel (service id first, req_last on the final byte); a byte that
// is not final is taken every cycle, even while a response still drains. On the
// final byte the request is decoded in the same cycle and the whole response
// (length byte first, at most seven bytes) is loaded into a shift buffer that
// feeds the output, one byte per cycle while out_stall_i is low. A final byte is
// held off only while the previous response still has bytes that will not leave
// in that cycle. Unless the lockout limit is reached, security subfunctions other
// than seed and key give no response. boot_phase on every response byte is the
// phase after that request. The APB port holds the seed, key xor mask, key add
// offset and lockout limit; the user must write it only while no request is in
// progress, and the block itself does not enforce this.
module uds_bootloader_service_handler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  uds_bl_pkg::req_t     in_data_i,
  // response channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output uds_bl_pkg::resp_t    out_data_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // configuration registers
  logic [31:0] seed_q, xor_mask_q, add_ofs_q;
  logic [7:0]  max_att_q;

  // request state
  logic [7:0]  head_q [uds_bl_pkg::HeadDepth];
  logic [7:0]  head_d [uds_bl_pkg::HeadDepth];
  logic [7:0]  pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic        unlocked_q, unlocked_d;
  logic [7:0]  failed_q, failed_d;
  logic [31:0] issued_q, issued_d;
  logic [31:0] exp_size_q, exp_size_d;
  logic [31:0] recv_q, recv_d;
  logic [15:0] new_ver_q, new_ver_d;
  logic [15:0] run_ver_q, run_ver_d;

  // response buffer
  logic [7:0]  buf_q [uds_bl_pkg::RespDepth];
  logic [7:0]  resp_d [uds_bl_pkg::RespDepth];
  logic [2:0]  rem_q, len_d;

  logic        in_acc, out_acc, req_end, cfg_wr;

  assign out_acc = out_valid_o & ~out_stall_i;
  // a final byte waits until the buffer is empty or empties in this cycle
  assign in_stall_o = in_data_i.req_last &
                      ((rem_q > 3'd1) | ((rem_q == 3'd1) & out_stall_i));
  assign in_acc  = in_valid_i & ~in_stall_o;
  assign req_end = in_acc & in_data_i.req_last;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= uds_bl_pkg::SeedReset;
      xor_mask_q <= uds_bl_pkg::XorMaskReset;
      add_ofs_q  <= uds_bl_pkg::AddOfsReset;
      max_att_q  <= uds_bl_pkg::MaxAttReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        uds_bl_pkg::REG_SEED:     seed_q     <= pwdata;
        uds_bl_pkg::REG_XOR_MASK: xor_mask_q <= pwdata;
        uds_bl_pkg::REG_ADD_OFS:  add_ofs_q  <= pwdata;
        uds_bl_pkg::REG_MAX_ATT:  max_att_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      uds_bl_pkg::REG_SEED:     prdata = seed_q;
      uds_bl_pkg::REG_XOR_MASK: prdata = xor_mask_q;
      uds_bl_pkg::REG_ADD_OFS:  prdata = add_ofs_q;
      uds_bl_pkg::REG_MAX_ATT:  prdata = {24'd0, max_att_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // head with the incoming byte merged in, saturating byte count
  always_comb begin
    for (int i = 0; i < uds_bl_pkg::HeadDepth; i++) begin
      head_d[i] = (pos_q == 8'(i)) ? in_data_i.req_byte : head_q[i];
    end
    pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
  end

  // request decode and response build
  always_comb begin
    logic [31:0] key_want, key_got, pay_len;
    logic [32:0] recv_sum;
    logic [7:0]  sid, sub;

    sid      = head_d[0];
    sub      = head_d[1];
    key_want = (issued_q ^ xor_mask_q) + add_ofs_q;
    key_got  = {head_d[2], head_d[3], head_d[4], head_d[5]};
    pay_len  = (pos_d >= 8'd2) ? {24'd0, pos_d - 8'd2} : 32'd0;
    recv_sum = {1'b0, recv_q} + {1'b0, pay_len};

    phase_d    = phase_q;
    unlocked_d = unlocked_q;
    failed_d   = failed_q;
    issued_d   = issued_q;
    exp_size_d = exp_size_q;
    recv_d     = recv_q;
    new_ver_d  = new_ver_q;
    run_ver_d  = run_ver_q;
    len_d      = 3'd0;
    for (int i = 0; i < uds_bl_pkg::RespDepth; i++) begin
      resp_d[i] = 8'd0;
    end

    unique case (sid)
      uds_bl_pkg::SID_DIAG_SESSION: begin
        len_d     = 3'd3;
        resp_d[0] = 8'h02;
        resp_d[1] = uds_bl_pkg::SID_DIAG_SESSION + uds_bl_pkg::SidPosOfs;
        resp_d[2] = sub;
      end
      uds_bl_pkg::SID_SECURITY: begin
        if (failed_q >= max_att_q) begin
          len_d     = 3'd4;
          resp_d[0] = 8'h03;
          resp_d[1] = uds_bl_pkg::SID_NEGATIVE;
          resp_d[2] = uds_bl_pkg::SID_SECURITY;
          resp_d[3] = uds_bl_pkg::NRC_LOCKED_OUT;
        end else if (sub == uds_bl_pkg::SUB_SEED) begin
          issued_d  = seed_q;
          len_d     = 3'd7;
          resp_d[0] = 8'h06;
          resp_d[1] = uds_bl_pkg::SID_SECURITY + uds_bl_pkg::SidPosOfs;
          resp_d[2] = uds_bl_pkg::SUB_SEED;
          resp_d[3] = seed_q[31:24];
          resp_d[4] = seed_q[23:16];
          resp_d[5] = seed_q[15:8];
          resp_d[6] = seed_q[7:0];
        end else if (sub == uds_bl_pkg::SUB_KEY) begin
          if (key_got == key_want) begin
            unlocked_d = 1'b1;
            len_d      = 3'd3;
            resp_d[0]  = 8'h02;
            resp_d[1]  = uds_bl_pkg::SID_SECURITY + uds_bl_pkg::SidPosOfs;
            resp_d[2]  = uds_bl_pkg::SUB_KEY;
          end else begin
            failed_d  = (failed_q == 8'hFF) ? failed_q : failed_q + 8'd1;
            len_d     = 3'd4;
            resp_d[0] = 8'h03;
            resp_d[1] = uds_bl_pkg::SID_NEGATIVE;
            resp_d[2] = uds_bl_pkg::SID_SECURITY;
            resp_d[3] = uds_bl_pkg::NRC_INVALID_KEY;
          end
        end
      end
      uds_bl_pkg::SID_DOWNLOAD: begin
        len_d     = 3'd4;
        resp_d[0] = 8'h03;
        if (!unlocked_q) begin
          resp_d[1] = uds_bl_pkg::SID_NEGATIVE;
          resp_d[2] = uds_bl_pkg::SID_DOWNLOAD;
          resp_d[3] = uds_bl_pkg::NRC_COND_WRONG;
        end else begin
          exp_size_d = {head_d[3], head_d[4], head_d[5], head_d[6]};
          new_ver_d  = {head_d[7], head_d[8]};
          recv_d     = 32'd0;
          phase_d    = uds_bl_pkg::PH_DL_REQ;
          resp_d[1]  = uds_bl_pkg::SID_DOWNLOAD + uds_bl_pkg::SidPosOfs;
          resp_d[2]  = 8'h20;
          resp_d[3]  = 8'h80;
        end
      end
      uds_bl_pkg::SID_DATA_TRANSFER: begin
        recv_d    = recv_sum[32] ? 32'hFFFF_FFFF : recv_sum[31:0];
        phase_d   = uds_bl_pkg::PH_DOWNLOAD;
        len_d     = 3'd3;
        resp_d[0] = 8'h02;
        resp_d[1] = uds_bl_pkg::SID_DATA_TRANSFER + uds_bl_pkg::SidPosOfs;
        resp_d[2] = sub;
      end
      uds_bl_pkg::SID_EXIT: begin
        phase_d   = uds_bl_pkg::PH_VERIFY;
        len_d     = 3'd2;
        resp_d[0] = 8'h01;
        resp_d[1] = uds_bl_pkg::SID_EXIT + uds_bl_pkg::SidPosOfs;
      end
      uds_bl_pkg::SID_RUN_ROUTINE: begin
        if ((new_ver_q <= run_ver_q) || (recv_q != exp_size_q)) begin
          // rollback attempt or size mismatch
          if (new_ver_q <= run_ver_q) begin
            phase_d = uds_bl_pkg::PH_ROLLBACK;
          end
          len_d     = 3'd4;
          resp_d[0] = 8'h03;
          resp_d[1] = uds_bl_pkg::SID_NEGATIVE;
          resp_d[2] = uds_bl_pkg::SID_RUN_ROUTINE;
          resp_d[3] = uds_bl_pkg::NRC_OUT_OF_RANGE;
        end else begin
          run_ver_d = new_ver_q;
          phase_d   = uds_bl_pkg::PH_COMPLETE;
          len_d     = 3'd5;
          resp_d[0] = 8'h04;
          resp_d[1] = uds_bl_pkg::SID_RUN_ROUTINE + uds_bl_pkg::SidPosOfs;
          resp_d[2] = 8'h01;
          resp_d[3] = 8'hFF;
          resp_d[4] = 8'h00;
        end
      end
      uds_bl_pkg::SID_ECU_RESET: begin
        len_d     = 3'd3;
        resp_d[0] = 8'h02;
        resp_d[1] = uds_bl_pkg::SID_ECU_RESET + uds_bl_pkg::SidPosOfs;
        resp_d[2] = 8'h01;
      end
      default: begin
        len_d     = 3'd4;
        resp_d[0] = 8'h03;
        resp_d[1] = uds_bl_pkg::SID_NEGATIVE;
        resp_d[2] = sid;
        resp_d[3] = uds_bl_pkg::NRC_NOT_SUPPORTED;
      end
    endcase
  end

  // head and byte count, cleared after every request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 8'd0;
      for (int i = 0; i < uds_bl_pkg::HeadDepth; i++) begin
        head_q[i] <= 8'd0;
      end
    end else if (in_acc) begin
      if (in_data_i.req_last) begin
        pos_q <= 8'd0;
        for (int i = 0; i < uds_bl_pkg::HeadDepth; i++) begin
          head_q[i] <= 8'd0;
        end
      end else begin
        pos_q  <= pos_d;
        head_q <= head_d;
      end
    end
  end

  // session and update state, changed only at the end of a request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= uds_bl_pkg::PH_IDLE;
      unlocked_q <= 1'b0;
      failed_q   <= 8'd0;
      issued_q   <= 32'd0;
      exp_size_q <= 32'd0;
      recv_q     <= 32'd0;
      new_ver_q  <= 16'd0;
      run_ver_q  <= uds_bl_pkg::RunVerReset;
    end else if (req_end) begin
      phase_q    <= phase_d;
      unlocked_q <= unlocked_d;
      failed_q   <= failed_d;
      issued_q   <= issued_d;
      exp_size_q <= exp_size_d;
      recv_q     <= recv_d;
      new_ver_q  <= new_ver_d;
      run_ver_q  <= run_ver_d;
    end
  end

  // response shift buffer, byte zero faces the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else if (req_end) begin
      rem_q <= len_d;
    end else if (out_acc) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_end) begin
      buf_q <= resp_d;
    end else if (out_acc) begin
      for (int i = 0; i < uds_bl_pkg::RespDepth - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
      buf_q[uds_bl_pkg::RespDepth - 1] <= 8'd0;
    end
  end

  assign out_valid_o           = (rem_q != 3'd0);
  assign out_data_o.resp_byte  = buf_q[0];
  assign out_data_o.resp_last  = (rem_q == 3'd1);
  assign out_data_o.boot_phase = phase_q;

  // checks
  a_pos_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_end |=> (pos_q == 8'd0))
    else $error("byte count not cleared after request end");

  a_unlock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(unlocked_q))
    else $error("security unlock dropped");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && (rem_q == 3'd1) && !req_end) |=> !out_valid_o)
    else $error("response continues past its last byte");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_end |-> ((rem_q == 3'd0) || ((rem_q == 3'd1) && out_acc)))
    else $error("response buffer overwritten");

endmodule

/* dv/uds_bl_response_checker.sv */
module uds_bl_response_checker
  import uds_bl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel as seen on the wires
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_data_i,
  // response channel as seen on the wires
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  resp_t       out_data_i,
  // configuration bus
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // fixed bytes of the download and routine replies
  localparam logic [7:0] DlLenFormat  = 8'h20;
  localparam logic [7:0] DlMaxBlock   = 8'h80;
  localparam logic [7:0] RoutineStart = 8'h01;
  localparam logic [7:0] RoutineOkHi  = 8'hFF;
  localparam logic [7:0] RoutineOkLo  = 8'h00;

  // mirrored configuration
  logic [31:0] seed_cfg, xor_mask_cfg, add_ofs_cfg;
  logic [7:0]  max_att_cfg;

  // predicted handler state
  logic [7:0]  head [HeadDepth];
  logic [7:0]  byte_cnt;
  logic [2:0]  phase;
  logic        unlocked;
  logic [7:0]  failed_keys;
  logic [31:0] issued_seed;
  logic [31:0] expected_size;
  logic [31:0] received_count;
  logic [15:0] new_version;
  logic [15:0] run_ver_lo;

  // reply under construction and the responses still owed by the block
  logic [7:0] reply [$];
  resp_t      resp_q [$];
  int         mismatches;

  function automatic void emit(input logic [7:0] b);
    reply.push_back(b);
  endfunction

  function automatic void refuse(input logic [7:0] sid, input logic [7:0] code);
    emit(8'h03);
    emit(SID_NEGATIVE);
    emit(sid);
    emit(code);
  endfunction

  function automatic logic [31:0] head_word(input int i);
    return {head[i], head[i+1], head[i+2], head[i+3]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t       want;
    logic [31:0] key_want;
    logic [31:0] payload;
    if (!rst_ni) begin
      seed_cfg       = SeedReset;
      xor_mask_cfg   = XorMaskReset;
      add_ofs_cfg    = AddOfsReset;
      max_att_cfg    = MaxAttReset;
      foreach (head[i]) head[i] = '0;
      byte_cnt       = '0;
      phase          = PH_IDLE;
      unlocked       = 1'b0;
      failed_keys    = '0;
      issued_seed    = '0;
      expected_size  = '0;
      received_count = '0;
      new_version    = '0;
      run_ver_lo     = RunVerReset;
      resp_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // register writes on the configuration bus
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_SEED:     seed_cfg     = pwdata_i;
          REG_XOR_MASK: xor_mask_cfg = pwdata_i;
          REG_ADD_OFS:  add_ofs_cfg  = pwdata_i;
          REG_MAX_ATT:  max_att_cfg  = pwdata_i[7:0];
          default: ;
        endcase
      end

      // request byte transaction: collect, and decode on the final byte
      if (in_valid_i && !in_stall_i) begin
        if (byte_cnt < HeadDepth) head[byte_cnt] = in_data_i.req_byte;
        if (byte_cnt != 8'hFF) byte_cnt++;
        if (in_data_i.req_last) begin
          reply.delete();
          case (head[0])
            SID_DIAG_SESSION: begin
              emit(8'h02);
              emit(SID_DIAG_SESSION + SidPosOfs);
              emit(head[1]);
            end
            SID_SECURITY: begin
              if (failed_keys >= max_att_cfg) begin
                refuse(SID_SECURITY, NRC_LOCKED_OUT);
              end else if (head[1] == SUB_SEED) begin
                issued_seed = seed_cfg;
                emit(8'h06);
                emit(SID_SECURITY + SidPosOfs);
                emit(SUB_SEED);
                emit(issued_seed[31:24]);
                emit(issued_seed[23:16]);
                emit(issued_seed[15:8]);
                emit(issued_seed[7:0]);
              end else if (head[1] == SUB_KEY) begin
                key_want = (issued_seed ^ xor_mask_cfg) + add_ofs_cfg;
                if (head_word(2) == key_want) begin
                  unlocked = 1'b1;
                  emit(8'h02);
                  emit(SID_SECURITY + SidPosOfs);
                  emit(SUB_KEY);
                end else begin
                  if (failed_keys != 8'hFF) failed_keys++;
                  refuse(SID_SECURITY, NRC_INVALID_KEY);
                end
              end
              // any other subfunction stays silent
            end
            SID_DOWNLOAD: begin
              if (!unlocked) begin
                refuse(SID_DOWNLOAD, NRC_COND_WRONG);
              end else begin
                expected_size  = head_word(3);
                new_version    = {head[7], head[8]};
                received_count = '0;
                phase          = PH_DL_REQ;
                emit(8'h03);
                emit(SID_DOWNLOAD + SidPosOfs);
                emit(DlLenFormat);
                emit(DlMaxBlock);
              end
            end
            SID_DATA_TRANSFER: begin
              // payload is everything after sid and block counter
              payload = (byte_cnt >= 8'd2) ? 32'(byte_cnt) - 32'd2 : 32'd0;
              if (received_count > 32'hFFFF_FFFF - payload) received_count = '1;
              else received_count += payload;
              phase = PH_DOWNLOAD;
              emit(8'h02);
              emit(SID_DATA_TRANSFER + SidPosOfs);
              emit(head[1]);
            end
            SID_EXIT: begin
              phase = PH_VERIFY;
              emit(8'h01);
              emit(SID_EXIT + SidPosOfs);
            end
            SID_RUN_ROUTINE: begin
              if (new_version <= run_ver_lo) begin
                phase = PH_ROLLBACK;
                refuse(SID_RUN_ROUTINE, NRC_OUT_OF_RANGE);
              end else if (received_count != expected_size) begin
                refuse(SID_RUN_ROUTINE, NRC_OUT_OF_RANGE);
              end else begin
                run_ver_lo = new_version;
                phase      = PH_COMPLETE;
                emit(8'h04);
                emit(SID_RUN_ROUTINE + SidPosOfs);
                emit(RoutineStart);
                emit(RoutineOkHi);
                emit(RoutineOkLo);
              end
            end
            SID_ECU_RESET: begin
              emit(8'h02);
              emit(SID_ECU_RESET + SidPosOfs);
              emit(8'h01);
            end
            default: refuse(head[0], NRC_NOT_SUPPORTED);
          endcase
          foreach (reply[i]) begin
            want = '{resp_byte: reply[i], resp_last: (i == reply.size() - 1),
                     boot_phase: phase};
            resp_q.push_back(want);
          end
          foreach (head[i]) head[i] = '0;
          byte_cnt = '0;
        end
      end

      // response byte transaction: compare against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (resp_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected response byte %02h last %0b phase %0d", $time,
                     out_data_i.resp_byte, out_data_i.resp_last, out_data_i.boot_phase);
          mismatches++;
        end else begin
          want = resp_q.pop_front();
          if (out_data_i.resp_byte !== want.resp_byte ||
              out_data_i.resp_last !== want.resp_last ||
              out_data_i.boot_phase !== want.boot_phase) begin
            if (mismatches < 10)
              $display("%0t: response mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                       $time, want.resp_byte, want.resp_last, want.boot_phase,
                       out_data_i.resp_byte, out_data_i.resp_last, out_data_i.boot_phase);
            mismatches++;
          end
        end
      end

      pending_o    <= resp_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* dv/uds_bootloader_service_handler_tb.sv */
module uds_bootloader_service_handler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uds_bl_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 20;
  localparam int PressureHold = 300;

  typedef logic [7:0] msg_t [$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  resp_t       out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          cycles;
  int          items_sent;
  bit          dense;
  bit          pressure_go;
  bit          pressure_done;
  msg_t        msg;
  logic [7:0]  block_seq;
  logic [15:0] cur_ver;

  // configuration as last written, used to build valid keys
  logic [31:0] seed_set = SeedReset;
  logic [31:0] mask_set = XorMaskReset;
  logic [31:0] ofs_set  = AddOfsReset;

  uds_bootloader_service_handler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  uds_bl_response_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // response side back-pressure: bursts of random stall, one long hold-off
  initial begin
    int burst_left;
    int stall_pct;
    burst_left = 0;
    stall_pct  = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (PressureHold) @(posedge clk_i);
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(10, 60);
          case ($urandom_range(0, 9))
            0, 1, 2:       stall_pct = 0;
            3, 4, 5, 6, 7: stall_pct = 25;
            8:             stall_pct = 75;
            default:       stall_pct = 100;
          endcase
        end
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
        burst_left--;
        @(posedge clk_i);
      end
    end
  end

  // one request byte transaction, with a random gap in front
  task automatic send_byte(input logic [7:0] b, input logic last);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = (dense || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{req_byte: b, req_last: last};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // whole request held in msg, last flag on its final byte
  task automatic send_msg();
    dense = ($urandom_range(0, 3) == 0);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // setup and access phases, then the bus returns to idle before the next transaction
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] seed, input logic [31:0] mask,
                            input logic [31:0] ofs, input logic [7:0] max_att);
    apb_write(REG_SEED, seed);
    apb_write(REG_XOR_MASK, mask);
    apb_write(REG_ADD_OFS, ofs);
    apb_write(REG_MAX_ATT, {24'h0, max_att});
    seed_set = seed;
    mask_set = mask;
    ofs_set  = ofs;
  endtask

  // stop offering, let every owed response drain, then let silent requests settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // full update flow: seed, key, download, transfers, exit, verify-and-apply
  task automatic run_update();
    logic [31:0] key;
    logic [31:0] size;
    logic [15:0] ver;
    bit          apply_ok;
    int          left;
    int          chunk;
    msg = {SID_SECURITY, SUB_SEED};
    send_msg();
    key = (seed_set ^ mask_set) + ofs_set;
    if ($urandom_range(0, 9) == 0) key ^= 32'd1 << $urandom_range(0, 31);
    msg = {SID_SECURITY, SUB_KEY, key[31:24], key[23:16], key[15:8], key[7:0]};
    send_msg();
    size     = $urandom_range(0, 12);
    apply_ok = ($urandom_range(0, 5) != 0);
    if (!apply_ok) ver = 16'($urandom_range(0, cur_ver));
    else if (cur_ver > 16'hFF00) ver = 16'hFFFF;
    else ver = cur_ver + 16'($urandom_range(1, 255));
    msg = {SID_DOWNLOAD, 8'h00, 8'h44, size[31:24], size[23:16], size[15:8], size[7:0],
           ver[15:8], ver[7:0]};
    send_msg();
    left = size;
    do begin
      chunk = $urandom_range(0, (left > 20) ? 20 : left);
      msg = {SID_DATA_TRANSFER, block_seq};
      block_seq++;
      repeat (chunk) msg.push_back(8'($urandom_range(0, 255)));
      send_msg();
      left -= chunk;
    end while (left > 0);
    // occasionally overshoot the announced size
    if ($urandom_range(0, 7) == 0) begin
      msg = {SID_DATA_TRANSFER, block_seq, 8'($urandom_range(0, 255))};
      send_msg();
      apply_ok = 1'b0;
    end
    msg = {SID_EXIT};
    send_msg();
    msg = {SID_RUN_ROUTINE, 8'h01, 8'hFF, 8'h00};
    send_msg();
    if (apply_ok && ver > cur_ver) cur_ver = ver;
  endtask

  // free-form request: mostly known services, sometimes very long
  task automatic send_noise();
    int         len;
    logic [7:0] first;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 300) : $urandom_range(1, 10);
    case ($urandom_range(0, 9))
      0:       first = SID_DIAG_SESSION;
      1:       first = SID_ECU_RESET;
      2, 3:    first = SID_SECURITY;
      4:       first = SID_DOWNLOAD;
      5:       first = SID_DATA_TRANSFER;
      6:       first = SID_EXIT;
      7:       first = SID_RUN_ROUTINE;
      default: first = 8'($urandom_range(0, 255));
    endcase
    msg = {first};
    for (int i = 1; i < len; i++) begin
      if (i == 1 && $urandom_range(0, 1) == 1) msg.push_back(8'($urandom_range(1, 2)));
      else msg.push_back(8'($urandom_range(0, 255)));
    end
    send_msg();
  endtask

  task automatic random_phase(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 9) < 6) run_update();
      else send_noise();
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [31:0] key;
    items_sent    = 0;
    dense         = 1'b0;
    pressure_go   = 1'b0;
    pressure_done = 1'b0;
    block_seq     = '0;
    cur_ver       = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // download while still locked, one-byte request
    msg = {SID_DOWNLOAD};
    send_msg();
    // wrong key, then the right key for a seed that was never issued
    msg = {SID_SECURITY, SUB_KEY, 8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
    key = mask_set + ofs_set;
    msg = {SID_SECURITY, SUB_KEY, key[31:24], key[23:16], key[15:8], key[7:0]};
    send_msg();
    // unsupported subfunction gets no reply
    msg = {SID_SECURITY, 8'h03};
    send_msg();
    msg = {SID_SECURITY, SUB_SEED};
    send_msg();
    msg = {SID_DIAG_SESSION, 8'h03};
    send_msg();
    msg = {SID_ECU_RESET};
    send_msg();
    msg = {8'hFF};
    send_msg();
    // version not newer than the running one: rollback
    msg = {SID_DOWNLOAD, 8'h00, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
    msg = {SID_RUN_ROUTINE};
    send_msg();
    // size mismatch, then a completed update
    msg = {SID_DOWNLOAD, 8'h00, 8'h44, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
    send_msg();
    msg = {SID_DATA_TRANSFER, 8'h01};
    send_msg();
    msg = {SID_RUN_ROUTINE};
    send_msg();
    msg = {SID_DATA_TRANSFER, 8'h01, 8'hAA};
    send_msg();
    msg = {SID_EXIT};
    send_msg();
    msg = {SID_RUN_ROUTINE};
    send_msg();
    cur_ver = 16'h0001;
    drain();

    // extreme settings, with the long hold-off on the response side
    set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    pressure_go = 1'b1;
    random_phase(15);
    drain();

    // opposite extremes: security always refused
    set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 8'h00);
    random_phase(15);
    drain();

    // random keys and a tight attempt limit
    set_config($urandom, $urandom, $urandom, 8'($urandom_range(1, 5)));
    random_phase(15);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/uds_bl_pkg.sv
rtl/core/uds_bootloader_service_handler.sv
dv/uds_bl_response_checker.sv
dv/uds_bootloader_service_handler_tb.sv
